FILE: hdl/prc_pkg.sv
// shared types and codes of the pending completion ring tracker
// no dependencies
`default_nettype none
package prc_pkg;

  localparam int SLOT_W = 10;
  localparam int CFG_W  = 11;
  localparam int UC_W   = 8;

  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_POLL     = 2'd2;

  localparam logic [2:0] KIND_ACCEPT = 3'd0;
  localparam logic [2:0] KIND_FULL   = 3'd1;
  localparam logic [2:0] KIND_RESUME = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_EMPTY  = 3'd4;

  localparam logic [2:0] CC_NOT_DONE = 3'd0;
  localparam logic [2:0] CC_GOOD     = 3'd1;
  localparam logic [2:0] CC_DMA      = 3'd2;
  localparam logic [2:0] CC_HW       = 3'd3;
  localparam logic [2:0] CC_INSTR    = 3'd4;

  localparam logic [2:0] EC_NONE    = 3'd0;
  localparam logic [2:0] EC_DMA     = 3'd1;
  localparam logic [2:0] EC_HW      = 3'd2;
  localparam logic [2:0] EC_INSTR   = 3'd3;
  localparam logic [2:0] EC_UCODE   = 3'd4;
  localparam logic [2:0] EC_INVALID = 3'd5;

  localparam logic [1:0] REG_QUEUE_LENGTH  = 2'd0;
  localparam logic [1:0] REG_STOP_MARGIN   = 2'd1;
  localparam logic [1:0] REG_RESUME_MARGIN = 2'd2;
  localparam logic [1:0] REG_TRUNC_CODE    = 2'd3;

  localparam logic [CFG_W-1:0] RST_QUEUE_LENGTH  = 11'd1024;
  localparam logic [CFG_W-1:0] RST_STOP_MARGIN   = 11'd128;
  localparam logic [CFG_W-1:0] RST_RESUME_MARGIN = 11'd512;
  localparam logic [UC_W-1:0]  RST_TRUNC_CODE    = 8'd0;

  typedef struct packed {
    logic [1:0]        operation;
    logic              may_sleep;
    logic              trunc_hmac;
    logic [SLOT_W-1:0] entry_index;
    logic [2:0]        comp_code;
    logic [UC_W-1:0]   uc_code;
  } prc_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot_index;
    logic              throttle;
    logic              success;
    logic [2:0]        error_class;
    logic              last;
  } prc_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] queue_length;
    logic [CFG_W-1:0] stop_margin;
    logic [CFG_W-1:0] resume_margin;
    logic [UC_W-1:0]  trunc_code;
  } prc_cfg_t;

  typedef struct packed {
    logic            busy;
    logic            mark;
    logic            trunc;
    logic [2:0]      comp;
    logic [UC_W-1:0] uc;
  } prc_slot_t;

endpackage
`default_nettype wire

FILE: hdl/prc_if.sv
// request and result channel interfaces with valid/ready handshake
// depends on prc_pkg
`default_nettype none
interface prc_req_if
  import prc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic              may_sleep;
  logic              trunc_hmac;
  logic [SLOT_W-1:0] entry_index;
  logic [2:0]        comp_code;
  logic [UC_W-1:0]   uc_code;
  modport source (output valid, operation, may_sleep, trunc_hmac, entry_index, comp_code,
                  uc_code, input ready);
  modport sink (input valid, operation, may_sleep, trunc_hmac, entry_index, comp_code,
                uc_code, output ready);
endinterface

interface prc_rsp_if
  import prc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [SLOT_W-1:0] slot_index;
  logic              throttle;
  logic              success;
  logic [2:0]        error_class;
  logic              last;
  modport source (output valid, kind, slot_index, throttle, success, error_class, last,
                  input ready);
  modport sink (input valid, kind, slot_index, throttle, success, error_class, last,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/prc_front.sv
// front end: takes requests, drops unknown operations, queues the rest
// depends on prc_pkg
`default_nettype none
module prc_front
  import prc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire prc_item_t in_item,
  input  wire logic      clearing,
  output logic           item_valid,
  output prc_item_t      item,
  input  wire logic      item_pop
);

  prc_item_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, known_op;

  assign in_ready   = (cnt_r != 2'd2) && !clearing;
  assign known_op   = (in_item.operation == OP_SUBMIT) || (in_item.operation == OP_COMPLETE) ||
                      (in_item.operation == OP_POLL);
  assign push       = in_valid && in_ready && known_op;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign pop        = item_pop && item_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/prc_back.sv
// back end: entry memory, ring pointers and the sequencer that runs each request
// depends on prc_pkg
`default_nettype none
module prc_back
  import prc_pkg::*;
#(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire prc_cfg_t    cfg,
  input  wire logic        item_valid,
  input  wire prc_item_t   item,
  output logic             item_pop,
  output logic             clearing,
  output logic             out_valid,
  input  wire logic        out_ready,
  output prc_result_t      out_res
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int LW = PW + 1;
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam int SW = CW + 1;
  localparam int RW = LW + 1;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_EVAL1, ST_EVAL2, ST_DONE
  } state_t;

  state_t      state_r;
  prc_item_t   cur_r;
  prc_slot_t   mem [RING_DEPTH];
  prc_slot_t   rd_data_r, hd_r, wr_data;
  logic [PW-1:0] rd_addr, wr_addr, clr_r, head_r, tail_r, r_r, entry_addr;
  logic        rd_en, wr_en;
  logic [LW-1:0] out_cnt_r, eff_len, inc;
  logic [CW-1:0] qlen_w;
  logic [RW-1:0] r_sum;
  logic [PW-1:0] r_idx, head_next, tail_next;
  logic        thr, out_free, entry_ok, hd_ready, ok;
  logic [2:0]  ec;
  logic        out_valid_r, res_load;
  prc_result_t out_res_r;

  assign clearing  = (state_r == ST_CLR);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = !out_valid_r || out_ready;
  assign item_pop  = (state_r == ST_IDLE) && item_valid;
  assign entry_ok  = (32'(item.entry_index) < RING_DEPTH);
  assign entry_addr = PW'(item.entry_index);

  always_comb begin
    qlen_w = CW'(cfg.queue_length);
    if (qlen_w == '0) begin
      eff_len = LW'(1);
    end else if (qlen_w > CW'(RING_DEPTH)) begin
      eff_len = LW'(RING_DEPTH);
    end else begin
      eff_len = LW'(qlen_w);
    end
    inc = (CW'(cfg.resume_margin) > CW'(eff_len)) ? eff_len : LW'(cfg.resume_margin);
    r_sum = RW'(head_r) + RW'(inc);
    if (r_sum >= RW'(eff_len)) begin
      r_sum = r_sum - RW'(eff_len);
    end
    r_idx = PW'(r_sum);
    head_next = ((LW'(head_r) + LW'(1)) >= eff_len) ? '0 : PW'(LW'(head_r) + LW'(1));
    tail_next = ((LW'(tail_r) + LW'(1)) >= eff_len) ? '0 : PW'(LW'(tail_r) + LW'(1));
    thr = cur_r.may_sleep && ((SW'(out_cnt_r) + SW'(cfg.stop_margin)) > SW'(eff_len));
    hd_ready = rd_data_r.busy && (rd_data_r.comp != CC_NOT_DONE);
  end

  // a result is loaded into the output register
  always_comb begin
    res_load = out_free && (((state_r == ST_EVAL1) && (cur_r.operation == OP_SUBMIT)) ||
                            ((state_r == ST_EVAL1) && (cur_r.operation == OP_POLL) &&
                             !hd_ready) ||
                            ((state_r == ST_EVAL2) && rd_data_r.mark) ||
                            (state_r == ST_DONE));
  end

  // result classification of the retired head entry
  always_comb begin
    ok = 1'b0;
    ec = EC_NONE;
    unique case (hd_r.comp)
      CC_GOOD: begin
        if ((hd_r.uc == '0) || (hd_r.trunc && (hd_r.uc == cfg.trunc_code))) begin
          ok = 1'b1;
        end else begin
          ec = EC_UCODE;
        end
      end
      CC_DMA:   ec = EC_DMA;
      CC_HW:    ec = EC_HW;
      CC_INSTR: ec = EC_INSTR;
      default:  ec = EC_INVALID;
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_r;
    wr_en   = 1'b0;
    wr_addr = head_r;
    wr_data = '0;
    unique case (state_r)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
      end
      ST_IDLE: begin
        if (item_valid) begin
          unique case (item.operation)
            OP_SUBMIT: begin
              rd_en   = 1'b1;
              rd_addr = tail_r;
            end
            OP_COMPLETE: begin
              rd_en   = entry_ok;
              rd_addr = entry_addr;
            end
            default: begin
              rd_en   = 1'b1;
              rd_addr = head_r;
            end
          endcase
        end
      end
      ST_EVAL1: begin
        unique case (cur_r.operation)
          OP_SUBMIT: begin
            wr_en   = out_free && !rd_data_r.busy;
            wr_addr = tail_r;
            wr_data = '{busy: 1'b1, mark: thr, trunc: cur_r.trunc_hmac, comp: CC_NOT_DONE,
                        uc: '0};
          end
          OP_COMPLETE: begin
            wr_en   = rd_data_r.busy;
            wr_addr = PW'(cur_r.entry_index);
            wr_data = rd_data_r;
            wr_data.comp = cur_r.comp_code;
            wr_data.uc   = cur_r.uc_code;
          end
          default: begin
            rd_en   = hd_ready;
            rd_addr = r_idx;
          end
        endcase
      end
      ST_EVAL2: begin
        wr_en   = rd_data_r.mark && out_free;
        wr_addr = r_r;
        wr_data = rd_data_r;
        wr_data.mark = 1'b0;
      end
      default: begin
        wr_en   = out_free;
        wr_addr = head_r;
        wr_data = hd_r;
        wr_data.busy = 1'b0;
        wr_data.mark = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CLR: begin
          clr_r <= clr_r + PW'(1);
          if (32'(clr_r) == RING_DEPTH - 1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            cur_r <= item;
            if ((item.operation != OP_COMPLETE) || entry_ok) begin
              state_r <= ST_EVAL1;
            end
          end
        end
        ST_EVAL1: begin
          unique case (cur_r.operation)
            OP_SUBMIT: begin
              if (out_free) begin
                if (rd_data_r.busy) begin
                  out_res_r <= '{kind: KIND_FULL, slot_index: SLOT_W'(tail_r),
                                 throttle: 1'b0, success: 1'b0, error_class: EC_NONE,
                                 last: 1'b1};
                end else begin
                  out_res_r <= '{kind: KIND_ACCEPT, slot_index: SLOT_W'(tail_r),
                                 throttle: thr, success: 1'b0, error_class: EC_NONE,
                                 last: 1'b1};
                  out_cnt_r <= out_cnt_r + LW'(1);
                  tail_r    <= tail_next;
                end
                state_r <= ST_IDLE;
              end
            end
            OP_COMPLETE: begin
              state_r <= ST_IDLE;
            end
            default: begin
              if (hd_ready) begin
                hd_r    <= rd_data_r;
                r_r     <= r_idx;
                state_r <= ST_EVAL2;
              end else if (out_free) begin
                out_res_r <= '{kind: KIND_EMPTY, slot_index: SLOT_W'(head_r),
                               throttle: 1'b0, success: 1'b0, error_class: EC_NONE,
                               last: 1'b1};
                state_r   <= ST_IDLE;
              end
            end
          endcase
        end
        ST_EVAL2: begin
          if (!rd_data_r.mark) begin
            state_r <= ST_DONE;
          end else if (out_free) begin
            out_res_r <= '{kind: KIND_RESUME, slot_index: SLOT_W'(r_r),
                           throttle: 1'b0, success: 1'b0, error_class: EC_NONE,
                           last: 1'b0};
            if (r_r == head_r) begin
              hd_r.mark <= 1'b0;
            end
            state_r <= ST_DONE;
          end
        end
        default: begin
          if (out_free) begin
            out_res_r <= '{kind: KIND_DONE, slot_index: SLOT_W'(head_r),
                           throttle: 1'b0, success: ok, error_class: ec,
                           last: 1'b1};
            if (out_cnt_r != '0) begin
              out_cnt_r <= out_cnt_r - LW'(1);
            end
            head_r  <= head_next;
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pending_completion_ring_tracker_top.sv
// top level of the pending completion ring tracker: config registers, front and back
// depends on prc_pkg, prc_if, prc_front, prc_back
//
// In-order completion ring. After reset the entry memory is swept clear, during which
// no request is taken. Requests go through a two-entry queue to a sequencer around
// one single-port entry memory with registered read: a complete reads the entry and
// writes back its codes, a submit reads the tail slot and writes it if free, a poll
// reads the head and, when it is ready, the resume slot, then retires the head; steps
// with a result wait for a free output. Unknown operations are dropped at the front.
`default_nettype none
module pending_completion_ring_tracker_top
  import prc_pkg::*;
#(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  prc_req_if.sink          in_if,
  prc_rsp_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  prc_cfg_t    cfg_r;
  prc_item_t   in_item, item;
  prc_result_t res;
  logic        clearing, item_valid, item_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.queue_length  <= RST_QUEUE_LENGTH;
      cfg_r.stop_margin   <= RST_STOP_MARGIN;
      cfg_r.resume_margin <= RST_RESUME_MARGIN;
      cfg_r.trunc_code    <= RST_TRUNC_CODE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_QUEUE_LENGTH:  cfg_r.queue_length  <= pwdata[CFG_W-1:0];
        REG_STOP_MARGIN:   cfg_r.stop_margin   <= pwdata[CFG_W-1:0];
        REG_RESUME_MARGIN: cfg_r.resume_margin <= pwdata[CFG_W-1:0];
        default:           cfg_r.trunc_code    <= pwdata[UC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_QUEUE_LENGTH:  prdata = 32'(cfg_r.queue_length);
      REG_STOP_MARGIN:   prdata = 32'(cfg_r.stop_margin);
      REG_RESUME_MARGIN: prdata = 32'(cfg_r.resume_margin);
      default:           prdata = 32'(cfg_r.trunc_code);
    endcase
  end

  assign in_item = '{operation: in_if.operation, may_sleep: in_if.may_sleep,
                     trunc_hmac: in_if.trunc_hmac, entry_index: in_if.entry_index,
                     comp_code: in_if.comp_code, uc_code: in_if.uc_code};

  prc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_item    (in_item),
    .clearing   (clearing),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  prc_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .clearing   (clearing),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_res    (res)
  );

  assign out_if.kind        = res.kind;
  assign out_if.slot_index  = res.slot_index;
  assign out_if.throttle    = res.throttle;
  assign out_if.success     = res.success;
  assign out_if.error_class = res.error_class;
  assign out_if.last        = res.last;

endmodule
`default_nettype wire
